// ===== sv/mlfq_pkg.sv =====
// Shared types and codes of the multilevel feedback queue scheduler.
`timescale 1ns / 1ps
package mlfq_pkg;

    localparam int FIELD_ID_W = 10;
    localparam int MODE_W     = 2;
    localparam int LEVEL_W    = 2;
    localparam int QUANT_W    = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int NUMLVL_W   = 3;

    localparam logic [MODE_W-1:0] MODE_ADMIT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SCHED  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEVELS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM3   = 3'd5;

    typedef logic [3:0] t_cmd;

    localparam t_cmd CMD_NOP       = 4'd0;
    localparam t_cmd CMD_LOAD      = 4'd1;
    localparam t_cmd CMD_ADMIT     = 4'd2;
    localparam t_cmd CMD_REQUEUE   = 4'd3;
    localparam t_cmd CMD_PICK_RD   = 4'd4;
    localparam t_cmd CMD_PICK_DONE = 4'd5;
    localparam t_cmd CMD_NEXT_LVL  = 4'd6;
    localparam t_cmd CMD_SCAN_RD   = 4'd7;
    localparam t_cmd CMD_SCAN_NEXT = 4'd8;
    localparam t_cmd CMD_SHIFT_RD  = 4'd9;
    localparam t_cmd CMD_SHIFT_WR  = 4'd10;
    localparam t_cmd CMD_REM_DONE  = 4'd11;
    localparam t_cmd CMD_DROP_RUN  = 4'd12;
    localparam t_cmd CMD_NOTFOUND  = 4'd13;
    localparam t_cmd CMD_EMIT      = 4'd14;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              any_ready;
        logic              lvl_end;
        logic              cur_empty;
        logic              rd_match;
        logic              shift_more;
        logic              run_match;
    } t_stat;

endpackage

// ===== sv/mlfq_dp.sv =====
// Datapath: queue memory, level pointers, running slot, configuration and result registers.
`timescale 1ns / 1ps
module mlfq_dp import mlfq_pkg::*; #(
    parameter int LEVELS      = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [FIELD_ID_W-1:0] i_task_id,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_picked_valid,
    output logic [FIELD_ID_W-1:0] o_picked_id,
    output logic [LEVEL_W-1:0]    o_picked_level,
    output logic [QUANT_W-1:0]    o_quantum,
    output logic [STATUS_W-1:0]   o_status
);

    localparam int IW    = (ID_BITS < FIELD_ID_W) ? ID_BITS : FIELD_ID_W;
    localparam int DEPTH = LEVELS * QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int LCW   = $clog2(LEVELS + 1);
    localparam int HW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);

    logic [IW-1:0]         r_mem [DEPTH];
    logic [IW-1:0]         r_rdata;
    logic [HW-1:0]         r_head [LEVELS];
    logic [CW-1:0]         r_count [LEVELS];
    logic [IW-1:0]         r_run_id;
    logic                  r_run_valid;
    logic [LW-1:0]         r_run_level;
    logic                  r_policy;
    logic [NUMLVL_W-1:0]   r_num_levels;
    logic [QUANT_W-1:0]    r_quantum [4];
    logic [MODE_W-1:0]     r_mode;
    logic [IW-1:0]         r_id;
    logic [LCW-1:0]        r_lvl;
    logic [CW-1:0]         r_k;
    logic [LW-1:0]         r_pick_lvl;
    logic                  r_res_pv;
    logic [IW-1:0]         r_res_id;
    logic [LEVEL_W-1:0]    r_res_lvl;
    logic [QUANT_W-1:0]    r_res_q;
    logic [STATUS_W-1:0]   r_res_st;
    logic                  r_o_pv;
    logic [IW-1:0]         r_o_id;
    logic [LEVEL_W-1:0]    r_o_lvl;
    logic [QUANT_W-1:0]    r_o_q;
    logic [STATUS_W-1:0]   r_o_st;

    logic [LW-1:0]         w_lvl;
    logic [CW-1:0]         w_cnt;
    logic [HW-1:0]         w_head;
    logic                  w_any;
    logic [LW-1:0]         w_pick;
    logic [NUMLVL_W:0]     w_nl;
    logic [LW-1:0]         w_last;
    logic [LW:0]           w_up;
    logic [LW-1:0]         w_tgt;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [IW-1:0]         w_wdata;
    logic                  w_re;
    logic [AW-1:0]         w_raddr;
    logic [1:0]            w_qidx;

    // Physical address of the k-th entry behind the head of a level.
    function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] lvl,
                                                input logic [HW-1:0] head,
                                                input logic [CW-1:0] k);
        logic [CW:0]   sum;
        logic [HW-1:0] slot;
        sum = {{(CW + 1 - HW){1'b0}}, head} + {1'b0, k};
        if (sum >= (CW + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (CW + 1)'(QUEUE_DEPTH);
        end
        slot = sum[HW-1:0];
        return AW'(32'(lvl) * QUEUE_DEPTH) + AW'(slot);
    endfunction

    assign w_lvl  = r_lvl[LW-1:0];
    assign w_cnt  = r_count[w_lvl];
    assign w_head = r_head[w_lvl];

    always_comb begin
        w_any  = 1'b0;
        w_pick = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_count[i] != '0) begin
                w_any  = 1'b1;
                w_pick = LW'(i);
            end
        end
    end

    // Requeue target: level 0 in round robin, one level down otherwise, clamped at the last active level.
    always_comb begin
        w_nl = {1'b0, r_num_levels};
        if (w_nl == '0) begin
            w_nl = (NUMLVL_W + 1)'(1);
        end
        if (w_nl > (NUMLVL_W + 1)'(LEVELS)) begin
            w_nl = (NUMLVL_W + 1)'(LEVELS);
        end
        w_last = LW'(w_nl - (NUMLVL_W + 1)'(1));
        w_up   = {1'b0, r_run_level} + (LW + 1)'(1);
        if (!r_policy) begin
            w_tgt = '0;
        end else if (w_up > {1'b0, w_last}) begin
            w_tgt = w_last;
        end else begin
            w_tgt = w_up[LW-1:0];
        end
    end

    assign w_qidx = (32'(r_pick_lvl) < 3) ? 2'(r_pick_lvl) : 2'd3;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = r_id;
        w_re    = 1'b0;
        w_raddr = '0;
        unique case (i_cmd)
            CMD_ADMIT: begin
                w_we    = r_count[0] < CW'(QUEUE_DEPTH);
                w_waddr = slot_addr('0, r_head[0], r_count[0]);
            end
            CMD_REQUEUE: begin
                w_we    = r_run_valid && (r_count[w_tgt] < CW'(QUEUE_DEPTH));
                w_waddr = slot_addr(w_tgt, r_head[w_tgt], r_count[w_tgt]);
                w_wdata = r_run_id;
            end
            CMD_SHIFT_WR: begin
                w_we    = 1'b1;
                w_waddr = slot_addr(w_lvl, w_head, r_k);
                w_wdata = r_rdata;
            end
            CMD_PICK_RD: begin
                w_re    = w_any;
                w_raddr = slot_addr(w_pick, r_head[w_pick], '0);
            end
            CMD_SCAN_RD: begin
                w_re    = 1'b1;
                w_raddr = slot_addr(w_lvl, w_head, r_k);
            end
            CMD_SHIFT_RD: begin
                w_re    = 1'b1;
                w_raddr = slot_addr(w_lvl, w_head, r_k + CW'(1));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
            r_run_id     <= '0;
            r_run_valid  <= 1'b0;
            r_run_level  <= '0;
            r_policy     <= 1'b0;
            r_num_levels <= NUMLVL_W'(1);
            for (int i = 0; i < 4; i++) begin
                r_quantum[i] <= QUANT_W'(10);
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_POLICY:     r_policy     <= i_cfg_data[0];
                    CFG_NUM_LEVELS: r_num_levels <= i_cfg_data[NUMLVL_W-1:0];
                    CFG_QUANTUM0:   r_quantum[0] <= i_cfg_data;
                    CFG_QUANTUM1:   r_quantum[1] <= i_cfg_data;
                    CFG_QUANTUM2:   r_quantum[2] <= i_cfg_data;
                    CFG_QUANTUM3:   r_quantum[3] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            unique case (i_cmd)
                CMD_ADMIT: begin
                    if (r_count[0] < CW'(QUEUE_DEPTH)) begin
                        r_count[0] <= r_count[0] + CW'(1);
                    end
                end
                CMD_REQUEUE: begin
                    if (r_run_valid && (r_count[w_tgt] < CW'(QUEUE_DEPTH))) begin
                        r_count[w_tgt] <= r_count[w_tgt] + CW'(1);
                    end
                    r_run_valid <= 1'b0;
                end
                CMD_PICK_RD: begin
                    if (w_any) begin
                        r_head[w_pick]  <= (r_head[w_pick] == HW'(QUEUE_DEPTH - 1)) ?
                                           '0 : r_head[w_pick] + HW'(1);
                        r_count[w_pick] <= r_count[w_pick] - CW'(1);
                    end else begin
                        r_run_id    <= '0;
                        r_run_level <= '0;
                    end
                end
                CMD_PICK_DONE: begin
                    r_run_id    <= r_rdata;
                    r_run_valid <= 1'b1;
                    r_run_level <= r_pick_lvl;
                end
                CMD_REM_DONE: begin
                    r_count[w_lvl] <= w_cnt - CW'(1);
                end
                CMD_DROP_RUN: begin
                    r_run_id    <= '0;
                    r_run_valid <= 1'b0;
                    r_run_level <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencing counters and result fields carry no reset.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_LOAD: begin
                r_mode   <= i_mode;
                r_id     <= IW'(i_task_id);
                r_lvl    <= '0;
                r_k      <= '0;
                r_res_pv <= 1'b0;
                r_res_id <= '0;
                r_res_lvl <= '0;
                r_res_q  <= '0;
                r_res_st <= ST_OK;
            end
            CMD_ADMIT: begin
                if (r_count[0] >= CW'(QUEUE_DEPTH)) begin
                    r_res_st <= ST_FULL;
                end
            end
            CMD_REQUEUE: begin
                if (r_run_valid && (r_count[w_tgt] >= CW'(QUEUE_DEPTH))) begin
                    r_res_st <= ST_FULL;
                end
            end
            CMD_PICK_RD:   r_pick_lvl <= w_pick;
            CMD_PICK_DONE: begin
                r_res_pv  <= 1'b1;
                r_res_id  <= r_rdata;
                r_res_lvl <= LEVEL_W'(r_pick_lvl);
                r_res_q   <= r_quantum[w_qidx];
            end
            CMD_NEXT_LVL: begin
                r_lvl <= r_lvl + LCW'(1);
                r_k   <= '0;
            end
            CMD_SCAN_NEXT: r_k <= r_k + CW'(1);
            CMD_SHIFT_WR:  r_k <= r_k + CW'(1);
            CMD_NOTFOUND:  r_res_st <= ST_NOT_FOUND;
            CMD_EMIT: begin
                r_o_pv  <= r_res_pv;
                r_o_id  <= r_res_id;
                r_o_lvl <= r_res_lvl;
                r_o_q   <= r_res_q;
                r_o_st  <= r_res_st;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.mode       = r_mode;
        o_stat.any_ready  = w_any;
        o_stat.lvl_end    = (r_lvl == LCW'(LEVELS));
        o_stat.cur_empty  = (r_k >= w_cnt);
        o_stat.rd_match   = (r_rdata == r_id);
        o_stat.shift_more = ({1'b0, r_k} + (CW + 1)'(1)) < {1'b0, w_cnt};
        o_stat.run_match  = r_run_valid && (r_run_id == r_id);
    end

    assign o_picked_valid = r_o_pv;
    assign o_picked_id    = FIELD_ID_W'(r_o_id);
    assign o_picked_level = r_o_lvl;
    assign o_quantum      = r_o_q;
    assign o_status       = r_o_st;

endmodule

// ===== sv/mlfq_ctrl.sv =====
// Controller: state machine that sequences admit, schedule and remove operations.
`timescale 1ns / 1ps
module mlfq_ctrl import mlfq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_ADMIT   = 4'd2;
    localparam logic [3:0] S_REQ     = 4'd3;
    localparam logic [3:0] S_PICK    = 4'd4;
    localparam logic [3:0] S_PICK_W  = 4'd5;
    localparam logic [3:0] S_SCAN    = 4'd6;
    localparam logic [3:0] S_SCAN_C  = 4'd7;
    localparam logic [3:0] S_SHIFT   = 4'd8;
    localparam logic [3:0] S_SHIFT_W = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.mode)
                    MODE_ADMIT:  n_state = S_ADMIT;
                    MODE_SCHED:  n_state = S_REQ;
                    MODE_REMOVE: n_state = S_SCAN;
                    default:     n_state = S_DONE;
                endcase
            end
            S_ADMIT: begin
                o_cmd   = CMD_ADMIT;
                n_state = S_DONE;
            end
            S_REQ: begin
                o_cmd   = CMD_REQUEUE;
                n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd   = CMD_PICK_RD;
                n_state = i_stat.any_ready ? S_PICK_W : S_DONE;
            end
            S_PICK_W: begin
                o_cmd   = CMD_PICK_DONE;
                n_state = S_DONE;
            end
            S_SCAN: begin
                priority if (i_stat.lvl_end && i_stat.run_match) begin
                    o_cmd   = CMD_DROP_RUN;
                    n_state = S_PICK;
                end else if (i_stat.lvl_end) begin
                    o_cmd   = CMD_NOTFOUND;
                    n_state = S_DONE;
                end else if (i_stat.cur_empty) begin
                    o_cmd   = CMD_NEXT_LVL;
                end else begin
                    o_cmd   = CMD_SCAN_RD;
                    n_state = S_SCAN_C;
                end
            end
            S_SCAN_C: begin
                if (i_stat.rd_match) begin
                    n_state = S_SHIFT;
                end else begin
                    o_cmd   = CMD_SCAN_NEXT;
                    n_state = S_SCAN;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_more) begin
                    o_cmd   = CMD_SHIFT_RD;
                    n_state = S_SHIFT_W;
                end else begin
                    o_cmd   = CMD_REM_DONE;
                    n_state = S_DONE;
                end
            end
            S_SHIFT_W: begin
                o_cmd   = CMD_SHIFT_WR;
                n_state = S_SHIFT;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd   = CMD_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd == CMD_EMIT) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/multilevel_feedback_queue_scheduler.sv =====
// Top level of the multilevel feedback queue scheduler.
// The block keeps up to LEVELS FIFO ready queues of QUEUE_DEPTH task ids in
// one on-chip memory and works on one command beat at a time. Every accepted
// input beat produces exactly one result beat. A remove searches the queue
// memory level by level, visiting each entry in turn, and moves the entries
// behind a match up to close the gap; when the running task is removed it
// then picks a new task from the queues. The queue memory has a single
// read port with a registered output. A finished result waits in the output
// register, so the next command is taken while the previous result is still
// held. Configuration writes are taken in any cycle and must only be issued
// while no command is in flight.
`timescale 1ns / 1ps
module multilevel_feedback_queue_scheduler import mlfq_pkg::*; #(
    parameter int LEVELS      = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [FIELD_ID_W-1:0] i_task_id,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_picked_valid,
    output logic [FIELD_ID_W-1:0] o_picked_id,
    output logic [LEVEL_W-1:0]    o_picked_level,
    output logic [QUANT_W-1:0]    o_quantum,
    output logic [STATUS_W-1:0]   o_status,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Register writes are taken whenever they are offered, so the port never stalls.
    assign o_cfg_ready = 1'b1;

    mlfq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    mlfq_dp #(
        .LEVELS      (LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_mode         (i_mode),
        .i_task_id      (i_task_id),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_picked_valid (o_picked_valid),
        .o_picked_id    (o_picked_id),
        .o_picked_level (o_picked_level),
        .o_quantum      (o_quantum),
        .o_status       (o_status)
    );

endmodule

// ===== sv/mlfq_chk.sv =====
// Port checker for the scheduler and its bind to the top level.
`timescale 1ns / 1ps
module mlfq_chk import mlfq_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic                  o_picked_valid,
    input logic [FIELD_ID_W-1:0] o_picked_id,
    input logic [LEVEL_W-1:0]    o_picked_level,
    input logic [QUANT_W-1:0]    o_quantum,
    input logic [STATUS_W-1:0]   o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_picked_id)
            && $stable(o_status) && $stable(o_quantum))
        else $error("result beat changed while stalled");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_picked_valid |->
            o_picked_id == '0 && o_picked_level == '0 && o_quantum == '0)
        else $error("empty pick carries nonzero fields");

    a_notfound_nopick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_NOT_FOUND |-> !o_picked_valid)
        else $error("failed remove reported a pick");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second command taken while one is in flight");

endmodule

bind multilevel_feedback_queue_scheduler mlfq_chk u_chk (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the multilevel feedback queue scheduler.
`timescale 1ns / 1ps
module tb;
    import mlfq_pkg::*;

    localparam int LEVELS = 4;
    localparam int DEPTH  = 16;

    // Mode code that the block treats as a no-op.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [MODE_W-1:0]     i_mode;
    logic [FIELD_ID_W-1:0] i_task_id;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_picked_valid;
    logic [FIELD_ID_W-1:0] o_picked_id;
    logic [LEVEL_W-1:0]    o_picked_level;
    logic [QUANT_W-1:0]    o_quantum;
    logic [STATUS_W-1:0]   o_status;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    multilevel_feedback_queue_scheduler DUT (.*);

    // One result beat as the block reports it.
    typedef struct packed {
        logic                  valid;
        logic [FIELD_ID_W-1:0] id;
        logic [LEVEL_W-1:0]    level;
        logic [QUANT_W-1:0]    quantum;
        logic [STATUS_W-1:0]   status;
    } t_pick;

    // One directed row: command, and an optional typed-in expected result.
    typedef struct {
        logic [MODE_W-1:0]     mode;
        logic [FIELD_ID_W-1:0] id;
        bit                    typed;
        t_pick                 want;
    } t_row;

    // Private copy of the scheduler state.
    logic [FIELD_ID_W-1:0] lvl_ids [LEVELS][$];
    logic [FIELD_ID_W-1:0] run_id;
    logic [LEVEL_W-1:0]    run_lvl;
    bit                    run_on;
    logic                  cfg_policy;
    logic [NUMLVL_W-1:0]   cfg_levels;
    logic [QUANT_W-1:0]    cfg_quantum [4];

    t_pick pending_picks[$];
    int    fail_count;
    int    beats_seen;
    int    send_idle_pct;
    int    recv_idle_pct;
    int    hold_off_cycles;
    int    n_sched_hits;
    int    n_full;
    int    n_missing;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int active_levels();
        int n;
        n = cfg_levels;
        if (n == 0) n = 1;
        if (n > LEVELS) n = LEVELS;
        return n;
    endfunction

    // Requeue the running task, then hand out the head of the best level.
    function automatic void run_dispatch(ref t_pick res);
        int target;
        if (run_on) begin
            target = 0;
            if (cfg_policy) begin
                target = run_lvl + 1;
                if (target > active_levels() - 1) target = active_levels() - 1;
            end
            if (lvl_ids[target].size() >= DEPTH) res.status = ST_FULL;
            else lvl_ids[target].push_back(run_id);
            run_on = 0;
        end
        for (int l = 0; l < LEVELS; l++) begin
            if (lvl_ids[l].size() != 0) begin
                run_id      = lvl_ids[l].pop_front();
                run_lvl     = LEVEL_W'(l);
                run_on      = 1;
                res.valid   = 1'b1;
                res.id      = run_id;
                res.level   = LEVEL_W'(l);
                res.quantum = cfg_quantum[l < 3 ? l : 3];
                return;
            end
        end
        run_id  = '0;
        run_lvl = '0;
    endfunction

    function automatic t_pick predict_pick(logic [MODE_W-1:0] mode,
                                           logic [FIELD_ID_W-1:0] id);
        t_pick res;
        bit    hit;
        res = '0;
        hit = 0;
        case (mode)
            MODE_ADMIT: begin
                if (lvl_ids[0].size() >= DEPTH) res.status = ST_FULL;
                else lvl_ids[0].push_back(id);
            end
            MODE_SCHED: run_dispatch(res);
            MODE_REMOVE: begin
                for (int l = 0; l < LEVELS && !hit; l++) begin
                    for (int k = 0; k < lvl_ids[l].size(); k++) begin
                        if (lvl_ids[l][k] == id) begin
                            lvl_ids[l].delete(k);
                            hit = 1;
                            break;
                        end
                    end
                end
                if (!hit) begin
                    if (run_on && run_id == id) begin
                        run_on  = 0;
                        run_id  = '0;
                        run_lvl = '0;
                        run_dispatch(res);
                    end else begin
                        res.status = ST_NOT_FOUND;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Configuration writes happen only while the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_POLICY:     cfg_policy = val[0];
            CFG_NUM_LEVELS: cfg_levels = val[NUMLVL_W-1:0];
            CFG_QUANTUM0:   cfg_quantum[0] = val;
            CFG_QUANTUM1:   cfg_quantum[1] = val;
            CFG_QUANTUM2:   cfg_quantum[2] = val;
            CFG_QUANTUM3:   cfg_quantum[3] = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Offer one command beat; the prediction is queued as the beat is taken.
    task automatic send_cmd(logic [MODE_W-1:0] mode, logic [FIELD_ID_W-1:0] id,
                            bit typed, t_pick want);
        t_pick got;
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_task_id  <= id;
        do @(posedge i_clk); while (!o_in_ready);
        got = predict_pick(mode, id);
        if (typed && got != want) begin
            $display("%0t: directed row mismatch, typed %h predictor %h",
                     $time, want, got);
            fail_count++;
        end
        pending_picks.push_back(got);
        if (got.valid) n_sched_hits++;
        if (got.status == ST_FULL) n_full++;
        if (got.status == ST_NOT_FOUND) n_missing++;
        i_in_valid <= 1'b0;
        // The block is busy after it takes a beat, so nothing is lost here.
        @(posedge i_clk);
    endtask

    task automatic drain_and_settle();
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Receiver: random stalls, plus one long hold-off when requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_ready     <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker: every accepted beat is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_pick got;
        t_pick want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_picked_valid, o_picked_id, o_picked_level, o_quantum, o_status};
            beats_seen++;
            if (pending_picks.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                fail_count++;
            end else begin
                want = pending_picks.pop_front();
                if (got.valid !== want.valid) begin
                    $display("%0t: picked_valid expected %0d actual %0d",
                             $time, want.valid, got.valid);
                    fail_count++;
                end
                if (got.id !== want.id) begin
                    $display("%0t: picked_id expected %0d actual %0d",
                             $time, want.id, got.id);
                    fail_count++;
                end
                if (got.level !== want.level) begin
                    $display("%0t: picked_level expected %0d actual %0d",
                             $time, want.level, got.level);
                    fail_count++;
                end
                if (got.quantum !== want.quantum) begin
                    $display("%0t: quantum expected %0d actual %0d",
                             $time, want.quantum, got.quantum);
                    fail_count++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    fail_count++;
                end
            end
        end
    end

    // Picks a remove target that usually exists: a queued id or the running one.
    function automatic logic [FIELD_ID_W-1:0] likely_id();
        int l;
        l = $urandom_range(LEVELS - 1);
        if (lvl_ids[l].size() != 0 && $urandom_range(3) != 0)
            return lvl_ids[l][$urandom_range(lvl_ids[l].size() - 1)];
        if (run_on && $urandom_range(1)) return run_id;
        return FIELD_ID_W'($urandom_range(1023));
    endfunction

    // One random phase of well-formed traffic with some noise mixed in.
    task automatic random_phase(int count);
        logic [MODE_W-1:0]     mode;
        logic [FIELD_ID_W-1:0] id;
        int                    r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 40) begin
                mode = MODE_ADMIT;
                id   = FIELD_ID_W'($urandom_range(1023));
                // Occasionally a burst of admits drives level 0 to full.
                if ($urandom_range(19) == 0)
                    repeat (DEPTH) send_cmd(MODE_ADMIT, FIELD_ID_W'($urandom_range(1023)),
                                            0, '0);
            end else if (r < 72) begin
                mode = MODE_SCHED;
                id   = FIELD_ID_W'($urandom_range(1023));
            end else if (r < 97) begin
                mode = MODE_REMOVE;
                id   = likely_id();
            end else begin
                mode = MODE_UNUSED;
                id   = FIELD_ID_W'($urandom_range(1023));
            end
            send_cmd(mode, id, 0, '0);
        end
    endtask

    t_row rows[$];

    initial begin
        t_pick z;
        t_pick nf;
        t_pick q;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_mode      = MODE_ADMIT;
        i_task_id   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_POLICY;
        i_cfg_data  = '0;
        fail_count  = 0;
        beats_seen  = 0;
        n_sched_hits = 0;
        n_full      = 0;
        n_missing   = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cfg_policy  = 1'b0;
        cfg_levels  = 3'd1;
        for (int i = 0; i < 4; i++) cfg_quantum[i] = 8'd10;
        run_on  = 0;
        run_id  = '0;
        run_lvl = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows right after reset: nothing ready, misses, extremes.
        z  = '0;
        nf = '0;
        nf.status = ST_NOT_FOUND;
        rows.push_back('{MODE_SCHED, 10'd0, 1, z});
        rows.push_back('{MODE_REMOVE, 10'd1023, 1, nf});
        rows.push_back('{MODE_UNUSED, 10'h3ff, 1, z});
        rows.push_back('{MODE_ADMIT, 10'd1023, 1, z});
        rows.push_back('{MODE_ADMIT, 10'd0, 1, z});
        q = '0;
        q.valid = 1'b1; q.id = 10'd1023; q.quantum = 8'd10;
        rows.push_back('{MODE_SCHED, 10'd5, 1, q});
        rows.push_back('{MODE_ADMIT, 10'h2aa, 0, z});
        rows.push_back('{MODE_ADMIT, 10'h155, 0, z});
        rows.push_back('{MODE_REMOVE, 10'h155, 0, z});
        // Removing the running task forces a reschedule.
        rows.push_back('{MODE_REMOVE, 10'd1023, 0, z});
        rows.push_back('{MODE_ADMIT, 10'h2aa, 0, z});
        rows.push_back('{MODE_REMOVE, 10'h2aa, 0, z});
        rows.push_back('{MODE_SCHED, 10'd0, 0, z});
        rows.push_back('{MODE_SCHED, 10'd0, 0, z});
        foreach (rows[i]) send_cmd(rows[i].mode, rows[i].id, rows[i].typed, rows[i].want);
        // Fill level 0 past its depth to reach the full case.
        for (int i = 0; i < DEPTH + 2; i++) send_cmd(MODE_ADMIT, FIELD_ID_W'(i), 0, '0);
        drain_and_settle();

        // Multilevel feedback with extreme settings and demotion past the bottom.
        write_reg(CFG_POLICY, 8'd1);
        write_reg(CFG_NUM_LEVELS, 8'd4);
        write_reg(CFG_QUANTUM0, 8'd1);
        write_reg(CFG_QUANTUM1, 8'd255);
        write_reg(CFG_QUANTUM2, 8'd0);
        write_reg(CFG_QUANTUM3, 8'd128);
        send_idle_pct = 30;
        recv_idle_pct = 79;
        random_phase(280);

        // The receiver holds off while commands keep coming, so the block backs up.
        hold_off_cycles = 400;
        random_phase(20);
        // The sender pauses here until every result is in.
        drain_and_settle();

        write_reg(CFG_NUM_LEVELS, 8'd0);
        write_reg(CFG_QUANTUM0, 8'd255);
        send_idle_pct = 79;
        recv_idle_pct = 30;
        random_phase(240);
        drain_and_settle();

        write_reg(CFG_NUM_LEVELS, 8'd7);
        write_reg(CFG_QUANTUM3, 8'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(240);
        drain_and_settle();

        // Back to round robin with levels still occupied from before.
        write_reg(CFG_POLICY, 8'd0);
        write_reg(CFG_NUM_LEVELS, 8'd2);
        random_phase(200);
        drain_and_settle();

        $display("Covered admits, schedules, removes and idle mode under both policies;");
        $display("%0d beats checked, %0d picks, %0d full, %0d not found.",
                 beats_seen, n_sched_hits, n_full, n_missing);
        if (fail_count == 0) begin
            $display("** multilevel_feedback_queue_scheduler: PASSED **");
        end else begin
            $display("** multilevel_feedback_queue_scheduler: FAILED **");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #50ms;
        $display("** multilevel_feedback_queue_scheduler: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/mlfq_pkg.sv
sv/mlfq_dp.sv
sv/mlfq_ctrl.sv
sv/multilevel_feedback_queue_scheduler.sv
sv/mlfq_chk.sv
tb/tb.sv
